// ===== src/date_period_overlap_days_defines.svh =====
// Assertion macros shared by the date period overlap checker
`ifndef DATE_PERIOD_OVERLAP_DAYS_DEFINES_SVH
`define DATE_PERIOD_OVERLAP_DAYS_DEFINES_SVH

// Condition holds in the same cycle as the trigger
`define DPOD_ASSERT_NOW(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Condition holds in the cycle after the trigger
`define DPOD_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== src/dpod_pkg.sv =====
// Types, codes and calendar tables for the date period overlap block
package dpod_pkg;

	typedef struct packed {
		logic [4:0]  a_start_day;
		logic [3:0]  a_start_month;
		logic [13:0] a_start_year;
		logic [4:0]  a_end_day;
		logic [3:0]  a_end_month;
		logic [13:0] a_end_year;
		logic [4:0]  b_start_day;
		logic [3:0]  b_start_month;
		logic [13:0] b_start_year;
		logic [4:0]  b_end_day;
		logic [3:0]  b_end_month;
		logic [13:0] b_end_year;
	} dpod_in_t;

	typedef struct packed {
		logic [21:0] overlap_days;
		logic        date_error;
	} dpod_out_t;

	localparam int unsigned SerialW = 22;
	localparam int unsigned YearMax = 9999;

	// accumulator operations
	localparam logic [1:0] OP_HOLD = 2'd0;
	localparam logic [1:0] OP_LOAD = 2'd1;
	localparam logic [1:0] OP_ADD  = 2'd2;
	localparam logic [1:0] OP_SUB  = 2'd3;

	localparam logic [3:0] MONTH_FEB = 4'd2;

	// days in a month of a common year; February handled by the caller
	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] r;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
			4'd2:                                       r = 5'd28;
			default:                                    r = 5'd0;
		endcase
		return r;
	endfunction

	// days of a common year before the first of month m
	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd1:    r = 9'd0;
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/dpod_div25.sv =====
// Shared divide-by-25 unit: reciprocal multiply, exact for 12-bit operands
module dpod_div25 (
	input  logic [11:0] x,
	output logic [7:0]  q
);
	import dpod_pkg::*;

	logic [24:0] prod;

	// 5243 / 2^17 sits just above 1/25; the excess stays below one step for x < 4096
	assign prod = {13'd0, x} * 25'd5243;
	assign q    = prod[24:17];

endmodule

// ===== src/dpod_alu.sv =====
// Shared accumulator: load, add or subtract one operand per cycle, or hold
module dpod_alu (
	input  logic                        clk,
	input  logic [1:0]                  op,
	input  logic [dpod_pkg::SerialW-1:0] operand,
	output logic [dpod_pkg::SerialW-1:0] acc
);
	import dpod_pkg::*;

	logic [SerialW-1:0] acc_q;

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: acc_q <= operand;
			OP_ADD:  acc_q <= acc_q + operand;
			OP_SUB:  acc_q <= acc_q - operand;
			default: acc_q <= acc_q;
		endcase
	end

	assign acc = acc_q;

endmodule

// ===== src/date_period_overlap_days.sv =====
// Top level: day count of the overlap of two Gregorian date periods
//
//  channel   | direction | signals                  | handshake
//  ----------+-----------+--------------------------+------------------------------
//  request   | in        | dates (dpod_in_t)        | taken when start && !busy
//  result    | out       | result (dpod_out_t)      | shown for one cycle with done
//
// A request runs from acceptance to its done strobe through six steps of the
// shared accumulator per date for four dates, then one compare and one count step.
// The accumulator and the divide-by-25 unit are used at most once per step; busy stays
// high throughout. done rises with busy already low, so a new request may be
// taken in the cycle the result is shown. Reset clears the sequencer and done.
module date_period_overlap_days (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  dpod_pkg::dpod_in_t  dates,
	output logic                busy,
	output logic                done,
	output dpod_pkg::dpod_out_t result
);
	import dpod_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_DATE  = 2'd1;
	localparam logic [1:0] ST_ORDER = 2'd2;
	localparam logic [1:0] ST_COUNT = 2'd3;

	localparam logic [2:0] PH_CENT  = 3'd0;
	localparam logic [2:0] PH_QUAD  = 3'd1;
	localparam logic [2:0] PH_SUB   = 3'd2;
	localparam logic [2:0] PH_QCENT = 3'd3;
	localparam logic [2:0] PH_MDAY  = 3'd4;
	localparam logic [2:0] PH_STORE = 3'd5;

	localparam logic [1:0] IDX_LAST = 2'd3;

	logic [1:0]         state_q;
	logic [2:0]         phase_q;
	logic [1:0]         idx_q;
	dpod_in_t           in_q;
	logic               err_q;
	logic               leap_q;
	logic [7:0]         yq_q;
	logic [7:0]         p100_q;
	logic [7:0]         p400_q;
	logic [SerialW-1:0] s_q [4];
	logic [SerialW-1:0] lo_q;
	logic [SerialW-1:0] hi_q;
	logic               ord_q;
	logic               done_q;
	dpod_out_t          result_q;

	logic [4:0]         d;
	logic [3:0]         m;
	logic [13:0]        y;
	logic [13:0]        p;
	logic [11:0]        div_x;
	logic [7:0]         div_q;
	logic [1:0]         alu_op;
	logic [SerialW-1:0] alu_opnd;
	logic [SerialW-1:0] acc;
	logic [22:0]        m365;
	logic [14:0]        y100;
	logic               c100;
	logic               leap_now;
	logic [4:0]         dim;
	logic               date_ok;
	logic [9:0]         mday;

	// pick the date under work
	always_comb begin
		unique case (idx_q)
			2'd0: begin
				d = in_q.a_start_day;
				m = in_q.a_start_month;
				y = in_q.a_start_year;
			end
			2'd1: begin
				d = in_q.a_end_day;
				m = in_q.a_end_month;
				y = in_q.a_end_year;
			end
			2'd2: begin
				d = in_q.b_start_day;
				m = in_q.b_start_month;
				y = in_q.b_start_year;
			end
			default: begin
				d = in_q.b_end_day;
				m = in_q.b_end_month;
				y = in_q.b_end_year;
			end
		endcase
	end

	assign p = y - 14'd1;

	// y/4/25 = y/100, p/4/25 = p/100, p/16/25 = p/400
	always_comb begin
		case (phase_q)
			PH_CENT: div_x = y[13:2];
			PH_QUAD: div_x = p[13:2];
			default: div_x = {2'd0, p[13:4]};
		endcase
	end

	dpod_div25 u_div25 (
		.x (div_x),
		.q (div_q)
	);

	assign y100     = {7'd0, yq_q} * 15'd100;
	assign c100     = (y100 == {1'b0, y});
	assign leap_now = ((y[1:0] == 2'd0) && !c100) || (c100 && (yq_q[1:0] == 2'd0));
	assign dim      = (m == MONTH_FEB) ? (5'd28 + {4'd0, leap_q}) : month_len(m);
	assign date_ok  = (y != 14'd0) && (y <= 14'(YearMax)) && (m != 4'd0) && (m <= 4'd12)
		&& (d != 5'd0) && (d <= dim);
	assign mday     = {1'b0, days_before(m)} + {5'd0, d}
		+ {9'd0, leap_q && (m > MONTH_FEB)};
	assign m365     = {9'd0, p} * 23'd365;

	always_comb begin
		alu_op   = OP_HOLD;
		alu_opnd = m365[SerialW-1:0];
		if (state_q == ST_DATE) begin
			case (phase_q)
				PH_CENT: begin
					alu_op   = OP_LOAD;
					alu_opnd = m365[SerialW-1:0];
				end
				PH_QUAD: begin
					alu_op   = OP_ADD;
					alu_opnd = {10'd0, p[13:2]};
				end
				PH_SUB: begin
					alu_op   = OP_SUB;
					alu_opnd = {14'd0, p100_q};
				end
				PH_QCENT: begin
					alu_op   = OP_ADD;
					alu_opnd = {14'd0, p400_q};
				end
				PH_MDAY: begin
					alu_op   = OP_ADD;
					alu_opnd = {12'd0, mday};
				end
				default: begin
					alu_op   = OP_HOLD;
				end
			endcase
		end
	end

	dpod_alu u_alu (
		.clk     (clk),
		.op      (alu_op),
		.operand (alu_opnd),
		.acc     (acc)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_CENT;
			idx_q   <= 2'd0;
			err_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DATE;
						phase_q <= PH_CENT;
						idx_q   <= 2'd0;
						err_q   <= 1'b0;
					end
				end
				ST_DATE: begin
					if (phase_q == PH_MDAY && !date_ok) begin
						err_q <= 1'b1;
					end
					if (phase_q == PH_STORE) begin
						phase_q <= PH_CENT;
						if (idx_q == IDX_LAST) begin
							state_q <= ST_ORDER;
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end else begin
						phase_q <= phase_q + 3'd1;
					end
				end
				ST_ORDER: begin
					state_q <= ST_COUNT;
				end
				default: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			in_q <= dates;
		end
		if (state_q == ST_DATE) begin
			case (phase_q)
				PH_CENT:  yq_q   <= div_q;
				PH_QUAD: begin
					p100_q <= div_q;
					leap_q <= leap_now;
				end
				PH_SUB:   p400_q <= div_q;
				PH_STORE: s_q[idx_q] <= acc;
				default: ;
			endcase
		end
		if (state_q == ST_ORDER) begin
			lo_q  <= (s_q[0] >= s_q[2]) ? s_q[0] : s_q[2];
			hi_q  <= (s_q[1] <= s_q[3]) ? s_q[1] : s_q[3];
			ord_q <= (s_q[0] <= s_q[1]) && (s_q[2] <= s_q[3]);
		end
		if (state_q == ST_COUNT) begin
			result_q.date_error <= err_q;
			if (err_q || !ord_q || (lo_q > hi_q)) begin
				result_q.overlap_days <= '0;
			end else begin
				result_q.overlap_days <= hi_q - lo_q + 22'd1;
			end
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== src/dpod_chk.sv =====
// Port-level checker for the date period overlap block, bound to the top level
`include "date_period_overlap_days_defines.svh"

module dpod_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input dpod_pkg::dpod_out_t result
);
	import dpod_pkg::*;

	`DPOD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request taken but busy stayed low")
	`DPOD_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")
	`DPOD_ASSERT_NEXT(a_done_single, done, !done, "result shown for more than one cycle")
	`DPOD_ASSERT_NOW(a_err_zero, done && result.date_error, result.overlap_days == '0,
		"date error with a non-zero count")

endmodule

bind date_period_overlap_days dpod_chk u_dpod_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

// ===== tb/sv/date_period_overlap_days_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the date period overlap day counter
module date_period_overlap_days_tb;
	import dpod_pkg::*;

	localparam int unsigned RandomReqs = 600;
	localparam int unsigned StallLimit = 2000;
	localparam int unsigned DrainCycles = 40;

	typedef struct {
		int unsigned d;
		int unsigned m;
		int unsigned y;
	} cal_date_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	dpod_in_t  dates = '0;
	logic      busy;
	logic      done;
	dpod_out_t result;

	dpod_in_t    req_pending[$];
	dpod_out_t   overlap_expected[$];
	dpod_out_t   due;
	int unsigned total_reqs = 0;
	int unsigned served_cnt = 0;
	int unsigned fail_cnt = 0;
	int unsigned idle_run = 0;
	int unsigned idle_pct;
	bit          launch;

	date_period_overlap_days dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.dates  (dates),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	function automatic bit is_leap(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
		int unsigned r;
		if (m == MONTH_FEB) begin
			r = is_leap(y) ? 29 : 28;
		end else if (m == 4 || m == 6 || m == 9 || m == 11) begin
			r = 30;
		end else if (m >= 1 && m <= 12) begin
			r = 31;
		end else begin
			r = 0;
		end
		return r;
	endfunction

	function automatic bit date_ok(input cal_date_t c);
		if (c.y < 1 || c.y > YearMax || c.m < 1 || c.m > 12)
			return 1'b0;
		return c.d >= 1 && c.d <= month_days(c.m, c.y);
	endfunction

	// 0001-01-01 is day 1
	function automatic int unsigned day_number(input cal_date_t c);
		int unsigned p;
		int unsigned n;
		p = c.y - 1;
		n = 365 * p + p / 4 - p / 100 + p / 400;
		for (int unsigned k = 1; k < c.m; k++)
			n += month_days(k, c.y);
		return n + c.d;
	endfunction

	function automatic dpod_out_t predict_overlap(input dpod_in_t q);
		cal_date_t   c[4];
		int unsigned sn[4];
		int unsigned lo;
		int unsigned hi;
		dpod_out_t   r;
		bit          bad;
		c[0] = '{q.a_start_day, q.a_start_month, q.a_start_year};
		c[1] = '{q.a_end_day, q.a_end_month, q.a_end_year};
		c[2] = '{q.b_start_day, q.b_start_month, q.b_start_year};
		c[3] = '{q.b_end_day, q.b_end_month, q.b_end_year};
		r = '0;
		bad = 1'b0;
		for (int i = 0; i < 4; i++)
			if (!date_ok(c[i]))
				bad = 1'b1;
		if (bad) begin
			r.date_error = 1'b1;
			return r;
		end
		for (int i = 0; i < 4; i++)
			sn[i] = day_number(c[i]);
		lo = (sn[0] > sn[2]) ? sn[0] : sn[2];
		hi = (sn[1] < sn[3]) ? sn[1] : sn[3];
		if (sn[0] <= sn[1] && sn[2] <= sn[3] && lo <= hi)
			r.overlap_days = 22'(hi - lo + 1);
		return r;
	endfunction

	function automatic dpod_in_t pack_req(input cal_date_t as, input cal_date_t ae,
			input cal_date_t bs, input cal_date_t be);
		dpod_in_t r;
		r.a_start_day   = 5'(as.d);
		r.a_start_month = 4'(as.m);
		r.a_start_year  = 14'(as.y);
		r.a_end_day     = 5'(ae.d);
		r.a_end_month   = 4'(ae.m);
		r.a_end_year    = 14'(ae.y);
		r.b_start_day   = 5'(bs.d);
		r.b_start_month = 4'(bs.m);
		r.b_start_year  = 14'(bs.y);
		r.b_end_day     = 5'(be.d);
		r.b_end_month   = 4'(be.m);
		r.b_end_year    = 14'(be.y);
		return r;
	endfunction

	function automatic cal_date_t rand_date(input int unsigned y);
		cal_date_t c;
		c.y = y;
		c.m = $urandom_range(1, 12);
		// lean on month ends, where leap days live
		c.d = ($urandom_range(3) == 0) ? month_days(c.m, y) :
			$urandom_range(1, month_days(c.m, y));
		return c;
	endfunction

	function automatic dpod_in_t random_req();
		bit [95:0]   raw;
		cal_date_t   c[4];
		cal_date_t   t;
		int unsigned base;
		int unsigned pick;
		int unsigned y;
		pick = $urandom_range(99);
		if (pick < 8) begin
			raw = {$urandom(), $urandom(), $urandom()};
			return raw[91:0];
		end
		if (pick < 14)
			base = ($urandom_range(1) == 1) ? $urandom_range(1, 4) : $urandom_range(9994, 9999);
		else
			base = $urandom_range(1, 9999);
		for (int i = 0; i < 4; i++) begin
			if ($urandom_range(99) < 12)
				y = $urandom_range(1, 9999);
			else
				y = base + $urandom_range(0, 3);
			if (y > YearMax)
				y = YearMax;
			c[i] = rand_date(y);
		end
		// most periods run forwards
		for (int i = 0; i < 4; i += 2) begin
			if ($urandom_range(99) < 80 && day_number(c[i]) > day_number(c[i + 1])) begin
				t = c[i];
				c[i] = c[i + 1];
				c[i + 1] = t;
			end
		end
		if ($urandom_range(99) < 10) begin
			pick = $urandom_range(3);
			case ($urandom_range(3))
				0: c[pick].d = $urandom_range(29, 31);
				1: c[pick].m = ($urandom_range(1) == 1) ? 0 : $urandom_range(13, 15);
				2: c[pick].y = ($urandom_range(1) == 1) ? 0 : $urandom_range(10000, 16383);
				default: c[pick].d = 0;
			endcase
		end
		return pack_req(c[0], c[1], c[2], c[3]);
	endfunction

	function automatic dpod_in_t mk(input int unsigned ad, am, ay, ed, em, ey,
			bd, bm, by, fd, fm, fy);
		return pack_req('{ad, am, ay}, '{ed, em, ey}, '{bd, bm, by}, '{fd, fm, fy});
	endfunction

	// sender: hold the request until taken, then advance with random gaps by phase
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			dates <= '0;
		end else begin
			launch = 1'b1;
			if (start && !busy) begin
				overlap_expected.push_back(predict_overlap(dates));
				void'(req_pending.pop_front());
				served_cnt++;
			end else if (start) begin
				launch = 1'b0;
			end
			if (launch) begin
				case (total_reqs == 0 ? 0 : served_cnt * 4 / total_reqs)
					1:       idle_pct = 62;
					3:       idle_pct = 32;
					default: idle_pct = 0;
				endcase
				if (req_pending.size() > 0 && $urandom_range(99) >= idle_pct) begin
					start <= 1'b1;
					dates <= req_pending[0];
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (overlap_expected.size() == 0) begin
				$error("result with no request outstanding: overlap_days %0d date_error %0b",
					result.overlap_days, result.date_error);
				fail_cnt++;
			end else begin
				due = overlap_expected.pop_front();
				if (result.overlap_days !== due.overlap_days) begin
					$error("overlap_days: expected %0d, got %0d",
						due.overlap_days, result.overlap_days);
					fail_cnt++;
				end
				if (result.date_error !== due.date_error) begin
					$error("date_error: expected %0b, got %0b", due.date_error, result.date_error);
					fail_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_run = 0;
			else
				idle_run++;
			if (idle_run >= StallLimit) begin
				$display("** date_period_overlap_days: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		// whole calendar, both periods
		req_pending.push_back(mk(1, 1, 1, 31, 12, 9999, 1, 1, 1, 31, 12, 9999));
		// leap day shared
		req_pending.push_back(mk(29, 2, 2000, 29, 2, 2000, 29, 2, 2000, 29, 2, 2000));
		// periods meet on one day, then abut with no day shared
		req_pending.push_back(mk(1, 1, 2020, 15, 3, 2020, 15, 3, 2020, 1, 6, 2020));
		req_pending.push_back(mk(1, 1, 2020, 31, 12, 2020, 1, 1, 2021, 31, 12, 2021));
		// reversed periods
		req_pending.push_back(mk(10, 5, 2021, 9, 5, 2021, 1, 1, 2021, 31, 12, 2021));
		req_pending.push_back(mk(1, 1, 2021, 31, 12, 2021, 1, 7, 2021, 30, 6, 2021));
		// nested across a century
		req_pending.push_back(mk(1, 1, 1900, 31, 12, 2100, 28, 2, 1900, 1, 3, 1900));
		// century that is no leap year
		req_pending.push_back(mk(29, 2, 1900, 1, 3, 1900, 1, 1, 1900, 31, 12, 1900));
		req_pending.push_back(mk(29, 2, 2400, 1, 3, 2400, 29, 2, 2100, 31, 12, 2100));
		// bad day, month and year, spread over all four slots
		req_pending.push_back(mk(0, 1, 2000, 1, 2, 2000, 1, 1, 2000, 1, 2, 2000));
		req_pending.push_back(mk(1, 1, 2000, 1, 2, 2000, 1, 1, 2000, 31, 4, 2000));
		req_pending.push_back(mk(1, 0, 2000, 1, 2, 2000, 1, 1, 2000, 1, 2, 2000));
		req_pending.push_back(mk(1, 1, 2000, 1, 2, 2000, 1, 13, 2000, 1, 2, 2000));
		req_pending.push_back(mk(1, 1, 2000, 31, 15, 2000, 1, 1, 2000, 1, 2, 2000));
		req_pending.push_back(mk(1, 1, 0, 1, 2, 2000, 1, 1, 2000, 1, 2, 2000));
		req_pending.push_back(mk(1, 1, 2000, 1, 2, 2000, 1, 1, 2000, 1, 2, 16383));
		req_pending.push_back(mk(1, 1, 2000, 1, 2, 10000, 1, 1, 2000, 1, 2, 2000));
		// single-day periods, apart and together at the calendar ends, then a year-end crossing
		req_pending.push_back(mk(5, 6, 2010, 5, 6, 2010, 6, 6, 2010, 6, 6, 2010));
		req_pending.push_back(mk(1, 1, 9999, 31, 12, 9999, 31, 12, 9999, 31, 12, 9999));
		req_pending.push_back(mk(1, 1, 1, 1, 1, 1, 1, 1, 1, 31, 12, 1));
		req_pending.push_back(mk(31, 12, 1999, 1, 1, 2000, 1, 1, 2000, 31, 12, 2000));
		// all fields zero, then all ones
		req_pending.push_back('0);
		req_pending.push_back('1);
		for (int i = 0; i < RandomReqs; i++)
			req_pending.push_back(random_req());
		total_reqs = req_pending.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		wait (served_cnt == total_reqs && overlap_expected.size() == 0);
		repeat (DrainCycles) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("** date_period_overlap_days: PASSED **");
		end else begin
			$display("** date_period_overlap_days: FAILED **");
		end
		$finish;
	end

endmodule
